/* rtl/rwp_pkg.sv */
// ----------------------------------------------------------------------------
// rwp_pkg
// Shared types and constants of the relocation word patcher.
// ----------------------------------------------------------------------------
package rwp_pkg;

    // default store sizes
    localparam int CODE_BYTES_DEF   = 4096;
    localparam int SYMBOL_SLOTS_DEF = 64;

    // fixed field widths
    localparam int POS_W   = 12;
    localparam int SLOT_W  = 6;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int SIZE_W  = 13;

    // configuration register indexes
    localparam logic REG_SECTION_START = 1'b0;
    localparam logic REG_SECTION_SIZE  = 1'b1;

    // request codes
    typedef enum logic [1:0] {
        REQ_WR_BYTE = 2'd0,
        REQ_WR_SYM  = 2'd1,
        REQ_RELOC   = 2'd2,
        REQ_RD_BYTE = 2'd3
    } req_t;

    // status codes
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_NO_SYM = 2'd2
    } status_t;

    // one symbol table entry, valid flag kept in memory
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] address;
        logic [WORD_W-1:0] local_val;
        logic              global_flag;
        logic [WORD_W-1:0] id;
    } sym_entry_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_BYTE,
        ST_SCAN,
        ST_RD_LO,
        ST_RD_HI,
        ST_WR_LO,
        ST_WR_HI,
        ST_RESP
    } state_t;

endpackage

/* rtl/rwp_ram.sv */
// ----------------------------------------------------------------------------
// rwp_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rwp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/relocation_word_patcher.sv */
// ----------------------------------------------------------------------------
// relocation_word_patcher
// Patches 16-bit little-endian words in a section's code store using a
// symbol table; also loads code bytes and symbol entries and reads bytes.
//
//   channel   dir   handshake          payload
//   s_        in    s_tvalid/s_tready  request (tdata fields, tuser kind)
//   m_        out   m_tvalid/m_tready  read byte, patched word, status
//   cfg_      in    cfg_wr_en          section_start, section_size
//
// The symbol scan reads the symbol memory one slot per cycle. After reset a
// clearing pass wipes the symbol table; no request is taken during it. One
// request is in work at a time; a new one is taken while the last result
// waits in the output register.
// ----------------------------------------------------------------------------
module relocation_word_patcher
    import rwp_pkg::*;
#(
    parameter int CODE_BYTES   = CODE_BYTES_DEF,
    parameter int SYMBOL_SLOTS = SYMBOL_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // position, byte_value, symbol_slot, symbol_id, symbol_global,
    // local_value, global_address, zero pad
    input  logic [79:0] s_tdata,
    // req_type, is_relative
    input  logic [2:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // read_byte, patched_word
    output logic [23:0] m_tdata,
    // status
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int CAW = $clog2(CODE_BYTES);
    localparam int SW  = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
    localparam int LW  = 18;
    localparam int EW  = $bits(sym_entry_t);
    localparam logic [LW-1:0] CODE_BYTES_L = LW'(CODE_BYTES);
    localparam logic [10:0]   SLOTS_L      = 11'(SYMBOL_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT    = SW'(SYMBOL_SLOTS - 1);

    // input fields
    logic [POS_W-1:0]  in_pos;
    logic [BYTE_W-1:0] in_byte;
    logic [SLOT_W-1:0] in_slot;
    logic [WORD_W-1:0] in_id;
    logic              in_global;
    logic [WORD_W-1:0] in_local;
    logic [WORD_W-1:0] in_gaddr;
    req_t              in_req;
    logic              in_rel;

    assign in_pos    = s_tdata[11:0];
    assign in_byte   = s_tdata[19:12];
    assign in_slot   = s_tdata[25:20];
    assign in_id     = s_tdata[41:26];
    assign in_global = s_tdata[42];
    assign in_local  = s_tdata[58:43];
    assign in_gaddr  = s_tdata[74:59];
    assign in_req    = req_t'(s_tuser[1:0]);
    assign in_rel    = s_tuser[2];

    // registers
    state_t            state_reg, state_next;
    logic [SW-1:0]     cnt_reg, cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [WORD_W-1:0] id_reg, id_next;
    logic              rel_reg, rel_next;
    sym_entry_t        ent_reg, ent_next;
    logic [BYTE_W-1:0] lo_reg, lo_next;
    logic [BYTE_W-1:0] rbyte_reg, rbyte_next;
    logic [WORD_W-1:0] word_reg, word_next;
    status_t           stat_reg, stat_next;
    logic              m_valid_reg, m_valid_next;
    logic [23:0]       m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;
    logic [WORD_W-1:0] start_reg;
    logic [SIZE_W-1:0] size_reg;

    // memory ports
    logic              code_we;
    logic [CAW-1:0]    code_waddr, code_raddr;
    logic [BYTE_W-1:0] code_wdata, code_rdata;
    logic              sym_we;
    logic [SW-1:0]     sym_waddr, sym_raddr;
    sym_entry_t        sym_wdata, sym_rdata;
    logic [EW-1:0]     sym_rdata_raw;

    assign sym_rdata = sym_entry_t'(sym_rdata_raw);

    rwp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CODE_BYTES),
        .AW    (CAW)
    ) u_code_ram (
        .aclk  (aclk),
        .we    (code_we),
        .waddr (code_waddr),
        .wdata (code_wdata),
        .raddr (code_raddr),
        .rdata (code_rdata)
    );

    rwp_ram #(
        .WIDTH (EW),
        .DEPTH (SYMBOL_SLOTS),
        .AW    (SW)
    ) u_sym_ram (
        .aclk  (aclk),
        .we    (sym_we),
        .waddr (sym_waddr),
        .wdata (sym_wdata),
        .raddr (sym_raddr),
        .rdata (sym_rdata_raw)
    );

    // derived addresses and checks
    logic [LW-1:0]     in_pos_ext, pos_ext, pos_p1_ext, pos_p2_ext, size_ext, limit;
    logic [10:0]       in_slot_ext;
    logic [WORD_W-1:0] old_word, sym_addr, calc_word;
    logic              in_pos_ok, in_slot_ok, sym_hit;

    assign in_pos_ext  = LW'(in_pos);
    assign pos_ext     = LW'(pos_reg);
    assign pos_p1_ext  = pos_ext + LW'(1);
    assign pos_p2_ext  = pos_ext + LW'(2);
    assign size_ext    = LW'(size_reg);
    assign limit       = (size_ext > CODE_BYTES_L) ? CODE_BYTES_L : size_ext;
    assign in_slot_ext = 11'(in_slot);
    assign in_pos_ok   = in_pos_ext < CODE_BYTES_L;
    assign in_slot_ok  = in_slot_ext < SLOTS_L;
    assign sym_hit     = sym_rdata.valid && (sym_rdata.id == id_reg);

    // patched word from the stored word and the matched entry
    assign old_word = {code_rdata, lo_reg};
    assign sym_addr = ent_reg.global_flag ? ent_reg.address : ent_reg.local_val;
    always_comb begin
        if (!rel_reg) begin
            calc_word = ent_reg.global_flag ? sym_addr : sym_addr + old_word;
        end else begin
            calc_word = sym_addr - start_reg - WORD_W'(pos_reg) + old_word;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            size_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SECTION_START: start_reg <= cfg_wdata;
                REG_SECTION_SIZE:  size_reg  <= cfg_wdata[SIZE_W-1:0];
                default:           start_reg <= start_reg;
            endcase
        end
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        id_reg     <= id_next;
        rel_reg    <= rel_next;
        ent_reg    <= ent_next;
        lo_reg     <= lo_next;
        rbyte_reg  <= rbyte_next;
        word_reg   <= word_next;
        stat_reg   <= stat_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        id_next      = id_reg;
        rel_next     = rel_reg;
        ent_next     = ent_reg;
        lo_next      = lo_reg;
        rbyte_next   = rbyte_reg;
        word_next    = word_reg;
        stat_next    = stat_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        s_tready     = 1'b0;
        code_we      = 1'b0;
        code_waddr   = pos_ext[CAW-1:0];
        code_wdata   = word_reg[7:0];
        code_raddr   = pos_ext[CAW-1:0];
        sym_we       = 1'b0;
        sym_waddr    = cnt_reg;
        sym_wdata    = '0;
        sym_raddr    = '0;

        unique case (state_reg)
            // wipe the symbol table after reset
            ST_CLEAR: begin
                sym_we = 1'b1;
                if (cnt_reg == LAST_SLOT) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + SW'(1);
                end
            end

            // take a request
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    pos_next   = in_pos;
                    id_next    = in_id;
                    rel_next   = in_rel;
                    rbyte_next = '0;
                    word_next  = '0;
                    stat_next  = STAT_OK;
                    cnt_next   = '0;
                    code_raddr = in_pos_ext[CAW-1:0];
                    unique case (in_req)
                        REQ_WR_BYTE: begin
                            code_we    = in_pos_ok;
                            code_waddr = in_pos_ext[CAW-1:0];
                            code_wdata = in_byte;
                            stat_next  = in_pos_ok ? STAT_OK : STAT_RANGE;
                            state_next = ST_RESP;
                        end
                        REQ_WR_SYM: begin
                            sym_we    = in_slot_ok;
                            sym_waddr = in_slot_ext[SW-1:0];
                            sym_wdata = '{valid: 1'b1, address: in_gaddr,
                                          local_val: in_local,
                                          global_flag: in_global, id: in_id};
                            stat_next  = in_slot_ok ? STAT_OK : STAT_RANGE;
                            state_next = ST_RESP;
                        end
                        REQ_RD_BYTE: begin
                            if (in_pos_ok) begin
                                state_next = ST_RD_BYTE;
                            end else begin
                                stat_next  = STAT_RANGE;
                                state_next = ST_RESP;
                            end
                        end
                        REQ_RELOC: begin
                            sym_raddr  = '0;
                            state_next = ST_SCAN;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            ST_RD_BYTE: begin
                rbyte_next = code_rdata;
                state_next = ST_RESP;
            end

            // walk the symbol table, lowest matching slot wins
            ST_SCAN: begin
                if (sym_hit) begin
                    ent_next = sym_rdata;
                    if (pos_p2_ext > limit) begin
                        stat_next  = STAT_RANGE;
                        state_next = ST_RESP;
                    end else begin
                        code_raddr = pos_ext[CAW-1:0];
                        state_next = ST_RD_LO;
                    end
                end else if (cnt_reg == LAST_SLOT) begin
                    stat_next  = STAT_NO_SYM;
                    state_next = ST_RESP;
                end else begin
                    cnt_next  = cnt_reg + SW'(1);
                    sym_raddr = cnt_reg + SW'(1);
                end
            end

            ST_RD_LO: begin
                lo_next    = code_rdata;
                code_raddr = pos_p1_ext[CAW-1:0];
                state_next = ST_RD_HI;
            end

            ST_RD_HI: begin
                word_next  = calc_word;
                state_next = ST_WR_LO;
            end

            ST_WR_LO: begin
                code_we    = 1'b1;
                code_waddr = pos_ext[CAW-1:0];
                code_wdata = word_reg[7:0];
                state_next = ST_WR_HI;
            end

            ST_WR_HI: begin
                code_we    = 1'b1;
                code_waddr = pos_p1_ext[CAW-1:0];
                code_wdata = word_reg[15:8];
                state_next = ST_RESP;
            end

            // hand the result to the output register once it is free
            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {word_reg, rbyte_reg};
                    m_user_next  = stat_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
